>>> rtl/lirr_pkg.sv
// Shared types and constants for the linear interpolation rational resampler.
// Used by every module of the block; depends on nothing else.
package lirr_pkg;

  localparam int UP_REG_W   = 5;
  localparam int DOWN_REG_W = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_UP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SEG,
    ST_FLAT,
    ST_FINISH
  } lirr_state_t;

  // Command from the sequencer to the output stage.
  typedef struct packed {
    logic push;   // new kept point; the held one (if any) leaves as a non-final item
    logic flush;  // held point leaves as the final item of this run
    logic eos;    // the run belongs to the final sample of the signal
  } lirr_cmd_t;

  // Status from the output stage back to the sequencer.
  typedef struct packed {
    logic pend_v;
    logic out_free;
  } lirr_stat_t;

endpackage

>>> rtl/lirr_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses lirr_pkg only through the common import convention.
module lirr_divider import lirr_pkg::*; #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  // The partial remainder stays below the divisor, so it fits DEN_W bits.
  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

>>> rtl/lirr_out_stage.sv
// Output stage: holds the latest kept point until it is known whether it ends
// its run, then passes it to the output register. Depends on lirr_pkg.
module lirr_out_stage import lirr_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lirr_cmd_t              cmd,
  input  logic [SAMPLE_BITS-1:0] value,
  output lirr_stat_t             stat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] sample_out,
  output logic                   last_of_run,
  output logic                   end_of_signal
);

  logic                   pend_v;
  logic [SAMPLE_BITS-1:0] pend_val;
  logic                   out_free;

  assign out_free      = !out_valid || !out_stall;
  assign stat.pend_v   = pend_v;
  assign stat.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push && pend_v) begin
        out_valid     <= 1'b1;
        sample_out    <= pend_val;
        last_of_run   <= 1'b0;
        end_of_signal <= 1'b0;
      end else if (cmd.flush && pend_v) begin
        out_valid     <= 1'b1;
        sample_out    <= pend_val;
        last_of_run   <= 1'b1;
        end_of_signal <= cmd.eos;
        pend_v        <= 1'b0;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (cmd.push) begin
        pend_v   <= 1'b1;
        pend_val <= value;
      end
    end
  end

endmodule

>>> rtl/linear_interp_rational_resampler.sv
// Linear interpolation rational resampler, top level with the point sequencer.
// An item with a previous sample goes through the divider, then yields one interpolated
// point per cycle while the output does not stall (up, plus up more for a final sample),
// then a finish step. A new item is taken only once the last one is done, as the single
// divider and the single point adder serve one item at a time. Output stalls hold the sequencer.
// Reset (rst, synchronous) clears the registers to 1/1 and forgets the previous sample.
module linear_interp_rational_resampler import lirr_pkg::*; #(
  parameter int MAX_UP      = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic                   last_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] sample_out,
  output logic                   last_of_run,
  output logic                   end_of_signal
);

  localparam int UPW = $clog2(MAX_UP + 1);
  localparam int QW  = SAMPLE_BITS + 1;

  logic [UP_REG_W-1:0]   up_factor;
  logic [DOWN_REG_W-1:0] down_factor;
  logic [UPW-1:0]        up_eff;
  logic [DOWN_REG_W-1:0] down_eff;

  lirr_state_t state, state_next;

  logic [SAMPLE_BITS-1:0] prev_sample;
  logic                   have_prev;
  logic [DOWN_REG_W-1:0]  keep_phase;
  logic [SAMPLE_BITS-1:0] cur_l;
  logic                   last_l;
  logic                   d_neg;
  logic [QW-1:0]          q;
  logic [UPW-1:0]         r;
  logic [QW-1:0]          dq;
  logic [UPW-1:0]         dr;
  logic [UPW-1:0]         j;

  logic [QW-1:0]          diff;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   div_start;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] mq;
  logic [UPW-1:0]         mr;

  logic [UPW:0]           r_sum;
  logic                   r_wrap;
  logic [UPW-1:0]         r_next;
  logic [QW-1:0]          q_next;
  logic [QW-1:0]          q_adj;
  logic [DOWN_REG_W-1:0]  kp_next;
  logic                   seg_end;
  logic                   adv;

  lirr_cmd_t              cmd;
  lirr_stat_t             stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      up_factor   <= UP_REG_W'(1);
      down_factor <= DOWN_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UP:   up_factor   <= cfg_data[UP_REG_W-1:0];
        CFG_DOWN: down_factor <= cfg_data[DOWN_REG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (up_factor == '0) begin
      up_eff = UPW'(1);
    end else if (int'(up_factor) > MAX_UP) begin
      up_eff = UPW'(MAX_UP);
    end else begin
      up_eff = UPW'(up_factor);
    end
    down_eff = (down_factor == '0) ? DOWN_REG_W'(1) : down_factor;
  end

  // Segment slope and its magnitude for the divider.
  always_comb begin
    diff = {sample_in[SAMPLE_BITS-1], sample_in} - {prev_sample[SAMPLE_BITS-1], prev_sample};
    mag  = diff[QW-1] ? SAMPLE_BITS'(QW'(0) - diff) : diff[SAMPLE_BITS-1:0];
  end

  lirr_divider #(
    .NUM_W (SAMPLE_BITS),
    .DEN_W (UPW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (up_eff),
    .done      (div_done),
    .quotient  (mq),
    .remainder (mr)
  );

  // The point value is kept as floor quotient q and remainder r of the exact
  // numerator; each step adds the floor-divided slope dq, dr.
  always_comb begin
    r_sum   = {1'b0, r} + {1'b0, dr};
    r_wrap  = r_sum >= {1'b0, up_eff};
    r_next  = r_wrap ? UPW'(r_sum - {1'b0, up_eff}) : r_sum[UPW-1:0];
    q_next  = q + dq + QW'(r_wrap);
    // Truncation toward zero differs from floor only for a negative inexact value.
    q_adj   = (q[QW-1] && r != '0) ? q + QW'(1) : q;
    kp_next = (keep_phase + DOWN_REG_W'(1) >= down_eff) ? '0 : keep_phase + DOWN_REG_W'(1);
    seg_end = j == up_eff - UPW'(1);
    adv     = !stat.pend_v || stat.out_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (have_prev) begin
            state_next = ST_DIVIDE;
          end else if (last_sample) begin
            state_next = ST_FLAT;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_SEG;
        end
      end
      ST_SEG: begin
        if (adv && seg_end) begin
          state_next = last_l ? ST_FLAT : ST_FINISH;
        end
      end
      ST_FLAT: begin
        if (adv && seg_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    cmd       = '0;
    cmd.eos   = last_l;
    unique case (state) inside
      ST_IDLE: begin
        in_stall  = rst;
        div_start = in_valid && have_prev;
      end
      ST_DIVIDE: ;
      ST_SEG, ST_FLAT: begin
        cmd.push = adv && (keep_phase == '0);
      end
      ST_FINISH: begin
        cmd.flush = stat.pend_v && stat.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      have_prev   <= 1'b0;
      keep_phase  <= '0;
      prev_sample <= '0;
    end else begin
      state <= state_next;
      unique case (state) inside
        ST_IDLE: begin
          if (in_valid) begin
            cur_l       <= sample_in;
            last_l      <= last_sample;
            d_neg       <= diff[QW-1];
            prev_sample <= sample_in;
            have_prev   <= !last_sample;
            if (keep_phase >= down_eff) begin
              keep_phase <= '0;
            end
            q  <= have_prev ? {prev_sample[SAMPLE_BITS-1], prev_sample}
                            : {sample_in[SAMPLE_BITS-1], sample_in};
            r  <= '0;
            dq <= '0;
            dr <= '0;
            j  <= '0;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            if (d_neg) begin
              dq <= QW'(0) - {1'b0, mq} - QW'(mr != '0);
              dr <= (mr != '0) ? up_eff - mr : '0;
            end else begin
              dq <= {1'b0, mq};
              dr <= mr;
            end
          end
        end
        ST_SEG, ST_FLAT: begin
          if (adv) begin
            keep_phase <= kp_next;
            if (seg_end) begin
              // The flat segment of the final sample starts from that sample.
              q  <= {cur_l[SAMPLE_BITS-1], cur_l};
              r  <= '0;
              dq <= '0;
              dr <= '0;
              j  <= '0;
            end else begin
              q <= q_next;
              r <= r_next;
              j <= j + UPW'(1);
            end
          end
        end
        ST_FINISH: begin
          if (last_l) begin
            keep_phase <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  lirr_out_stage #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .value         (q_adj[SAMPLE_BITS-1:0]),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .last_of_run   (last_of_run),
    .end_of_signal (end_of_signal)
  );

`ifndef SYNTH
  a_idle_nothing_held: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !stat.pend_v)
    else $error("point held back while the sequencer is idle");

  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEG || state == ST_FLAT) |-> r < up_eff)
    else $error("interpolation remainder not below the up factor");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE || state == ST_SEG || state == ST_FLAT) |-> keep_phase < down_eff)
    else $error("decimation phase not below the down factor");

  a_finish_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !stat.pend_v) |=> state == ST_IDLE)
    else $error("finish state held with nothing to flush");
`endif

endmodule

>>> test/lirr_checker.sv
// Scoreboard for the linear interpolation rational resampler: mirrors the ratio
// registers, predicts the kept points of every accepted item and checks each result.
// Depends on lirr_pkg for the register widths and indexes.
module lirr_checker import lirr_pkg::*; #(
  parameter int MAX_UP      = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic                   last_sample,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [SAMPLE_BITS-1:0] sample_out,
  input  logic                   last_of_run,
  input  logic                   end_of_signal,
  output int                     errors,
  output int                     awaited,
  output int                     predicted,
  output int                     checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [SAMPLE_BITS-1:0] value;
    logic                   run_end;
    logic                   sig_end;
  } point_t;

  point_t expected_points[$];
  point_t run_points[$];
  point_t want;

  logic [UP_REG_W-1:0]           up_reg;
  logic [DOWN_REG_W-1:0]         down_reg;
  logic signed [SAMPLE_BITS-1:0] prev_smp;
  logic                          have_prev;
  int                            keep_phase;

  initial begin
    errors    = 0;
    awaited   = 0;
    predicted = 0;
    checked   = 0;
  end

  // Walks one segment of up points from f0 towards f1, keeping every down-th point.
  task automatic walk_segment(input longint f0, input longint f1, input int up,
                              input int down);
    int     j;
    longint num;
    point_t p;
    for (j = 0; j < up; j++) begin
      if (keep_phase == 0) begin
        num       = f0 * up + j * (f1 - f0);
        p.value   = SAMPLE_BITS'(num / up);
        p.run_end = 1'b0;
        p.sig_end = 1'b0;
        run_points.push_back(p);
      end
      keep_phase++;
      if (keep_phase >= down) begin
        keep_phase = 0;
      end
    end
  endtask

  task automatic resample_item(input logic [SAMPLE_BITS-1:0] smp, input logic fin);
    int     up;
    int     down;
    longint cur;
    up   = (up_reg == 0) ? 1 : ((up_reg > MAX_UP) ? MAX_UP : int'(up_reg));
    down = (down_reg == 0) ? 1 : int'(down_reg);
    if (keep_phase >= down) begin
      keep_phase = 0;
    end
    cur = longint'(signed'(smp));
    run_points.delete();
    if (have_prev) begin
      walk_segment(longint'(prev_smp), cur, up, down);
    end
    prev_smp  = smp;
    have_prev = 1'b1;
    // The final sample of a signal is held flat for one more segment.
    if (fin) begin
      walk_segment(cur, cur, up, down);
      have_prev  = 1'b0;
      keep_phase = 0;
    end
    if (run_points.size() > 0) begin
      run_points[run_points.size() - 1].run_end = 1'b1;
      run_points[run_points.size() - 1].sig_end = fin;
    end
    foreach (run_points[i]) begin
      expected_points.push_back(run_points[i]);
    end
    predicted += run_points.size();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      up_reg     = UP_REG_W'(1);
      down_reg   = DOWN_REG_W'(1);
      prev_smp   = '0;
      have_prev  = 1'b0;
      keep_phase = 0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_UP: begin
            up_reg = cfg_data[UP_REG_W-1:0];
          end
          CFG_DOWN: begin
            down_reg = cfg_data[DOWN_REG_W-1:0];
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected item, expected none, got sample_out %0d",
                   $time, signed'(sample_out));
        end else begin
          want = expected_points.pop_front();
          if (sample_out !== want.value) begin
            errors++;
            $display("%0t ns: sample_out expected %0d, got %0d", $time,
                     signed'(want.value), signed'(sample_out));
          end
          if (last_of_run !== want.run_end) begin
            errors++;
            $display("%0t ns: last_of_run expected %b, got %b", $time,
                     want.run_end, last_of_run);
          end
          if (end_of_signal !== want.sig_end) begin
            errors++;
            $display("%0t ns: end_of_signal expected %b, got %b", $time,
                     want.sig_end, end_of_signal);
          end
        end
      end
      if (in_valid && !in_stall) begin
        resample_item(sample_in, last_sample);
      end
    end
    awaited = expected_points.size();
  end

endmodule

>>> test/tb.sv
// Top of the resampler testbench: clock, reset, ratio writes, sample stimulus and
// output back-pressure. Depends on lirr_pkg, the block and lirr_checker.
module tb import lirr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_UP        = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int SETTLE_CYCLES = 64;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   last_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   last_of_run;
  logic                   end_of_signal;

  int errors;
  int awaited;
  int predicted;
  int checked;

  int items_sent;
  int ratio_phases;
  int hold_out;
  bit tx_gaps_on;
  bit rx_gaps_on;
  logic [SAMPLE_BITS-1:0] last_value;

  linear_interp_rational_resampler #(
    .MAX_UP     (MAX_UP),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .last_sample  (last_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .last_of_run  (last_of_run),
    .end_of_signal(end_of_signal)
  );

  lirr_checker #(
    .MAX_UP     (MAX_UP),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .last_sample  (last_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .last_of_run  (last_of_run),
    .end_of_signal(end_of_signal),
    .errors       (errors),
    .awaited      (awaited),
    .predicted    (predicted),
    .checked      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("linear_interp_rational_resampler test failed");
    $finish;
  end

  // Output side: a random hold-off before each item, or one long hold when asked.
  initial begin
    int k;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      k = rx_gaps_on ? $urandom_range(0, 6) : 0;
      if (hold_out > 0) begin
        k        = hold_out;
        hold_out = 0;
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic fin);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample_in   <= smp;
    last_sample <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
    last_value = smp;
  endtask

  // Waits for every expected item, then lets the block finish points it may drop.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_ratio(input int up, input int down);
    settle();
    write_reg(CFG_UP, up);
    write_reg(CFG_DOWN, down);
    ratio_phases++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9)) inside
      0: return 16'h7FFF;
      1: return 16'h8000;
      [2:4]: return last_value + SAMPLE_BITS'($urandom_range(0, 64)) - 16'd32;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_signal(input int len, input bit finish);
    int i;
    for (i = 0; i < len; i++) begin
      send_sample(pick_sample(), finish && (i == len - 1));
    end
  endtask

  initial begin
    int up;
    int down;
    int signals;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    sample_in   = '0;
    last_sample = 1'b0;
    items_sent   = 0;
    ratio_phases = 0;
    hold_out     = 0;
    tx_gaps_on   = 1'b1;
    rx_gaps_on   = 1'b1;
    last_value   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset ratio of one to one, full-scale swings.
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b1);
    // Largest ratio up with nothing dropped: the widest run of results.
    set_ratio(16, 1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    // Zero factors behave as one; a signal of a single sample.
    set_ratio(0, 0);
    send_sample(16'd12345, 1'b1);
    // Up factor saturates; heavy decimation leaves the final item without a result.
    set_ratio(31, 255);
    send_sample(16'd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'd5, 1'b1);
    // Negative slopes truncate toward zero; the ratio then changes mid-signal and
    // the decimation phase has to wrap.
    set_ratio(3, 1);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'd8, 1'b0);
    set_ratio(3, 5);
    send_sample(-16'sd20, 1'b0);
    set_ratio(5, 2);
    send_sample(16'd1000, 1'b0);
    send_sample(-16'sd1001, 1'b1);
    set_ratio(4, 3);
    send_sample(16'h8000, 1'b1);

    // Long output hold while samples keep coming, so the block backs up.
    set_ratio(16, 1);
    hold_out   = 400;
    tx_gaps_on = 1'b0;
    send_signal(10, 1'b1);

    while (items_sent < 180) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: up = 0;
          1: up = 31;
          2: up = 1;
          default: up = 16;
        endcase
        case ($urandom_range(0, 2))
          0: down = 0;
          1: down = 255;
          default: down = 1;
        endcase
      end else begin
        up   = $urandom_range(1, 16);
        down = $urandom_range(1, up + 3);
      end
      set_ratio(up, down);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      signals = $urandom_range(1, 3);
      repeat (signals) begin
        // Most signals end properly; some are left open across a ratio change.
        send_signal($urandom_range(1, 8), $urandom_range(0, 4) != 0);
      end
    end

    settle();
    $display("Sent %0d samples over %0d ratio settings; %0d results predicted, %0d checked.",
             items_sent, ratio_phases, predicted, checked);
    if (errors == 0 && awaited == 0) begin
      $display("linear_interp_rational_resampler test passed");
    end else begin
      $display("linear_interp_rational_resampler test failed");
    end
    $finish;
  end

endmodule
